// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the palette stretcher.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define SPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication under synchronous reset.
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/sps_pkg.sv -----
// Types and fixed constants for the scanline palette stretcher.
// No dependencies; referenced by scoped name from the top level.
`timescale 1ns / 1ps

package sps_pkg;

   typedef enum logic [1:0] {
      ACT_PAL_WRITE  = 2'd0,
      ACT_LINE_START = 2'd1,
      ACT_PIXEL      = 2'd2
   } action_type;

   localparam logic [1:0] MODE_ONE_TO_ONE = 2'd0;
   localparam logic [1:0] MODE_FOUR_FIVE  = 2'd1;
   localparam logic [1:0] MODE_TWO_THREE  = 2'd2;

   localparam logic [1:0] CSR_STRETCH_MODE = 2'd0;
   localparam logic [1:0] CSR_COLUMN_SHIFT = 2'd1;

   localparam int         ACTIVE_ROWS = 216;
   localparam logic [3:0] BASE_SKIP   = 4'd8;

   // Pixel waiting between the palette read and the output register.
   typedef struct packed {
      logic [7:0] row;
      logic [8:0] col;
      logic       twice;
   } pix_type;

endpackage

// ----- hdl/scanline_palette_stretch.sv -----
// Top level of the scanline palette stretcher: palette memory, line control,
// a palette-read stage and a two-pixel output register. Uses sps_pkg and assert_macros.svh.
//
//   channel | dir | handshake           | payload
//   req_    | in  | req_valid/req_stall | action, palette and line fields, source byte
//   rsp_    | out | rsp_valid/rsp_stall | row, column, colour, last_of_run
//   csr_    | in  | csr_we              | csr_index, csr_wdata
//
// A request is taken every cycle while req_stall is low; its pixel goes to the read stage
// and then to the output register before it is on rsp. A doubled pixel holds the output
// register until both its pixels are sent; the sustained rate is set by the single rsp port.
// Palette writes and line starts produce no pixel.
// Synchronous reset clears control state; the palette is undefined until written.
// req_stall rises only while a looked-up pixel waits for the output register, which is
// either stalled or still holding the first pixel of a doubled pair.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scanline_palette_stretch #(
   parameter int SCREEN_WIDTH   = 384,
   parameter int VISIBLE_PIXELS = 240,
   parameter int FIRST_LINE     = 13,
   parameter int PALETTE_DEPTH  = 128
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [6:0]  req_palette_index,
   input  logic [15:0] req_palette_color,
   input  logic [8:0]  req_line_number,
   input  logic [7:0]  req_frame_count,
   input  logic [2:0]  req_scroll_offset,
   input  logic [7:0]  req_source_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_row,
   output logic [8:0]  rsp_out_column,
   output logic [15:0] rsp_out_color,
   output logic        rsp_last_of_run,

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

   localparam logic [8:0] BASE_ONE  = 9'((SCREEN_WIDTH - VISIBLE_PIXELS) / 2);
   localparam logic [8:0] BASE_FOUR = 9'((SCREEN_WIDTH - VISIBLE_PIXELS * 5 / 4) / 2);
   localparam logic [8:0] BASE_TWO  = 9'((SCREEN_WIDTH - VISIBLE_PIXELS * 3 / 2) / 2);

   localparam logic [8:0] LINE_LO  = 9'(FIRST_LINE);
   localparam logic [8:0] LINE_HI  = 9'(FIRST_LINE + sps_pkg::ACTIVE_ROWS);
   localparam logic [8:0] VIS_END  = 9'(VISIBLE_PIXELS);

   // Configuration
   logic [1:0] mode_ff;
   logic [5:0] shift_ff;

   // Line control
   logic       active_ff, active_in;
   logic [7:0] row_ff, row_in;
   logic [8:0] count_ff, count_in;
   logic [3:0] skip_ff, skip_in;
   logic [8:0] col_ff, col_in;
   logic [1:0] phase_ff, phase_in;

   // Palette memory and read stage
   logic [15:0]   palette_mem [PALETTE_DEPTH];
   logic [15:0]   rd_ff;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [8:0]    wr_wide, rd_wide;

   logic              s1_v_ff, s1_v_in;
   sps_pkg::pix_type  s1_ff, s1_in;

   // Output register
   logic        out_v_ff, out_v_in;
   logic        out_two_ff, out_two_in;
   logic [7:0]  out_row_ff, out_row_in;
   logic [8:0]  out_col_ff, out_col_in;
   logic [15:0] out_color_ff, out_color_in;

   logic req_acc, rsp_acc, s1_move;
   logic do_write, do_read, twice;
   logic [8:0] base;

   assign req_acc   = req_valid && !req_stall;
   assign rsp_acc   = rsp_valid && !rsp_stall;
   assign s1_move   = !out_v_ff || (rsp_acc && !out_two_ff);
   assign req_stall = s1_v_ff && !s1_move;

   // Fold an index into the palette depth; it never reaches twice the depth.
   assign wr_wide = ({2'b00, req_palette_index} >= DEPTH9) ?
                    ({2'b00, req_palette_index} - DEPTH9) : {2'b00, req_palette_index};
   assign rd_wide = ({2'b00, req_source_byte[7:1]} >= DEPTH9) ?
                    ({2'b00, req_source_byte[7:1]} - DEPTH9) : {2'b00, req_source_byte[7:1]};
   assign wr_addr = wr_wide[AW-1:0];
   assign rd_addr = rd_wide[AW-1:0];

   always_comb begin
      case (mode_ff)
         sps_pkg::MODE_FOUR_FIVE: base = BASE_FOUR;
         sps_pkg::MODE_TWO_THREE: base = BASE_TWO;
         default:                 base = BASE_ONE;
      endcase
   end

   always_comb begin
      case (mode_ff)
         sps_pkg::MODE_FOUR_FIVE: twice = (count_ff[1:0] == phase_ff);
         sps_pkg::MODE_TWO_THREE: twice = (count_ff[0] != phase_ff[0]);
         default:                 twice = 1'b0;
      endcase
   end

   // Line control and request decode
   always_comb begin
      active_in = active_ff;
      row_in    = row_ff;
      count_in  = count_ff;
      skip_in   = skip_ff;
      col_in    = col_ff;
      phase_in  = phase_ff;
      do_write  = 1'b0;
      do_read   = 1'b0;
      if (req_acc) begin
         case (req_action)
            sps_pkg::ACT_PAL_WRITE: begin
               do_write = 1'b1;
            end
            sps_pkg::ACT_LINE_START: begin
               if (req_line_number >= LINE_LO && req_line_number < LINE_HI) begin
                  active_in = 1'b1;
                  row_in    = 8'(req_line_number - LINE_LO);
                  count_in  = 9'd0;
                  skip_in   = sps_pkg::BASE_SKIP + {1'b0, req_scroll_offset};
                  col_in    = base + {3'b000, shift_ff};
                  phase_in  = req_frame_count[1:0] + req_line_number[1:0];
               end else begin
                  active_in = 1'b0;
               end
            end
            sps_pkg::ACT_PIXEL: begin
               if (active_ff) begin
                  if (skip_ff != 4'd0) begin
                     skip_in = skip_ff - 4'd1;
                  end else if (count_ff < VIS_END) begin
                     do_read  = 1'b1;
                     count_in = count_ff + 9'd1;
                     col_in   = col_ff + (twice ? 9'd2 : 9'd1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Read stage: the looked-up colour sits in rd_ff alongside s1_ff
   always_comb begin
      s1_v_in = s1_v_ff;
      s1_in   = s1_ff;
      if (do_read) begin
         s1_v_in     = 1'b1;
         s1_in.row   = row_ff;
         s1_in.col   = col_ff;
         s1_in.twice = twice;
      end else if (s1_move) begin
         s1_v_in = 1'b0;
      end
   end

   // Output register: the second pixel of a doubled pair advances the column
   always_comb begin
      out_v_in     = out_v_ff;
      out_two_in   = out_two_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_color_in = out_color_ff;
      if (s1_v_ff && s1_move) begin
         out_v_in     = 1'b1;
         out_two_in   = s1_ff.twice;
         out_row_in   = s1_ff.row;
         out_col_in   = s1_ff.col;
         out_color_in = rd_ff;
      end else if (rsp_acc) begin
         if (out_two_ff) begin
            out_two_in = 1'b0;
            out_col_in = out_col_ff + 9'd1;
         end else begin
            out_v_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= sps_pkg::MODE_ONE_TO_ONE;
         shift_ff   <= 6'd0;
         active_ff  <= 1'b0;
         row_ff     <= 8'd0;
         count_ff   <= 9'd0;
         skip_ff    <= 4'd0;
         col_ff     <= 9'd0;
         phase_ff   <= 2'd0;
         s1_v_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
         out_two_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == sps_pkg::CSR_STRETCH_MODE) begin
            mode_ff <= csr_wdata[1:0];
         end
         if (csr_we && csr_index == sps_pkg::CSR_COLUMN_SHIFT) begin
            shift_ff <= csr_wdata;
         end
         active_ff  <= active_in;
         row_ff     <= row_in;
         count_ff   <= count_in;
         skip_ff    <= skip_in;
         col_ff     <= col_in;
         phase_ff   <= phase_in;
         s1_v_ff    <= s1_v_in;
         out_v_ff   <= out_v_in;
         out_two_ff <= out_two_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_color_ff <= out_color_in;
   end

   // At most one request is taken per cycle, so a write and a read never meet on one edge;
   // a read after a write to the same entry sees the new colour.
   always_ff @(posedge clock) begin
      if (do_write) begin
         palette_mem[wr_addr] <= req_palette_color;
      end
      if (do_read) begin
         rd_ff <= palette_mem[rd_addr];
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_out_row     = out_row_ff;
   assign rsp_out_column  = out_col_ff;
   assign rsp_out_color   = out_color_ff;
   assign rsp_last_of_run = !out_two_ff;

   `SPS_ASSERT_NOW(a_hold_when_full, clock, reset,
      s1_v_ff && out_v_ff && rsp_stall, req_stall)
   `SPS_ASSERT_NEXT(a_second_pixel, clock, reset,
      rsp_valid && !rsp_stall && out_two_ff,
      rsp_valid && rsp_last_of_run && rsp_out_column == $past(rsp_out_column) + 9'd1)
   `SPS_ASSERT_NEXT(a_skip_no_pixel, clock, reset,
      req_valid && !req_stall && skip_ff != 4'd0, !s1_v_ff)

endmodule

// ----- tb/tb_scanline_palette_stretch.sv -----
// Self-checking testbench for scanline_palette_stretch: a directed table of requests, most
// with their expected pixels, then randomised scanlines across every stretch mode, checked
// against a local predictor. Depends on sps_pkg and the scanline_palette_stretch RTL.
`timescale 1ns / 1ps

module tb_scanline_palette_stretch;

   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam logic [1:0] MODE_SPARE  = 2'd3;
   localparam int SCREEN_W      = 384;
   localparam int VIS_PIX       = 240;
   localparam int TOP_LINE      = 13;
   localparam int PAL_DEPTH     = 128;
   localparam int PHASE_ITEMS   = 45;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 6;

   typedef struct packed {
      logic [1:0]  action;
      logic [6:0]  pal_idx;
      logic [15:0] pal_color;
      logic [8:0]  line;
      logic [7:0]  frame;
      logic [2:0]  scroll;
      logic [7:0]  src_byte;
   } line_req_type;

   localparam int REQ_BITS = $bits(line_req_type);

   typedef struct packed {
      logic [7:0]  row;
      logic [8:0]  column;
      logic [15:0] color;
      logic        last;
   } pixel_type;

   typedef struct packed {
      line_req_type req;
      logic         typed;
      logic [1:0]   n_pix;
      pixel_type    first_pix;
   } step_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [6:0]  req_palette_index;
   logic [15:0] req_palette_color;
   logic [8:0]  req_line_number;
   logic [7:0]  req_frame_count;
   logic [2:0]  req_scroll_offset;
   logic [7:0]  req_source_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_row;
   logic [8:0]  rsp_out_column;
   logic [15:0] rsp_out_color;
   logic        rsp_last_of_run;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [5:0]  csr_wdata;

   // predictor state
   logic [15:0] pal_shadow [PAL_DEPTH];
   bit          pal_known [PAL_DEPTH];
   logic [6:0]  known_idx [$];
   bit          line_live;
   logic [7:0]  row_now;
   logic [8:0]  src_taken;
   logic [3:0]  skip_left;
   logic [8:0]  col_next;
   logic [1:0]  dbl_phase;
   logic [1:0]  mode_now;
   logic [5:0]  shift_now;

   pixel_type pending_pixels [$];
   int        errors;
   int        quiet_cycles;
   int        useful_items;
   bit        idling_on;

   scanline_palette_stretch uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .req_line_number   (req_line_number),
      .req_frame_count   (req_frame_count),
      .req_scroll_offset (req_scroll_offset),
      .req_source_byte   (req_source_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_column    (rsp_out_column),
      .rsp_out_color     (rsp_out_color),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int scale_request(input line_req_type r, output pixel_type px [2]);
      logic [15:0] color;
      bit          twice;
      px[0] = '0;
      px[1] = '0;
      case (r.action)
         sps_pkg::ACT_PAL_WRITE: begin
            pal_shadow[r.pal_idx] = r.pal_color;
            return 0;
         end
         sps_pkg::ACT_LINE_START: begin
            if (r.line >= TOP_LINE && r.line < TOP_LINE + sps_pkg::ACTIVE_ROWS) begin
               line_live = 1'b1;
               row_now   = 8'(r.line - TOP_LINE);
               src_taken = '0;
               skip_left = sps_pkg::BASE_SKIP + {1'b0, r.scroll};
               dbl_phase = 2'(r.frame + r.line);
               // centre the stretched run, then apply the shift
               case (mode_now)
                  sps_pkg::MODE_FOUR_FIVE: col_next = 9'((SCREEN_W - VIS_PIX * 5 / 4) / 2);
                  sps_pkg::MODE_TWO_THREE: col_next = 9'((SCREEN_W - VIS_PIX * 3 / 2) / 2);
                  default:                 col_next = 9'((SCREEN_W - VIS_PIX) / 2);
               endcase
               col_next = col_next + {3'b000, shift_now};
            end else begin
               line_live = 1'b0;
            end
            return 0;
         end
         sps_pkg::ACT_PIXEL: begin
            if (!line_live)
               return 0;
            if (skip_left != 0) begin
               skip_left--;
               return 0;
            end
            if (src_taken >= VIS_PIX)
               return 0;
            color = pal_shadow[r.src_byte[7:1]];
            case (mode_now)
               sps_pkg::MODE_FOUR_FIVE: twice = (src_taken[1:0] == dbl_phase);
               sps_pkg::MODE_TWO_THREE: twice = src_taken[0] ? !dbl_phase[0] : dbl_phase[0];
               default:                 twice = 1'b0;
            endcase
            src_taken++;
            px[0] = {row_now, col_next, color, !twice};
            col_next++;
            if (!twice)
               return 1;
            px[1] = {row_now, col_next, color, 1'b1};
            col_next++;
            return 2;
         end
         default: return 0;
      endcase
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t: MISMATCH %s", $time, msg);
      errors++;
   endtask

   task automatic issue_request(input line_req_type r, input logic typed,
                                input logic [1:0] n_typed, input pixel_type typed_pix);
      pixel_type px [2];
      int        n;
      // steer looked-up bytes onto palette entries that hold a colour
      if (r.action == sps_pkg::ACT_PIXEL && line_live && skip_left == 0 &&
          src_taken < VIS_PIX && !pal_known[r.src_byte[7:1]])
         r.src_byte[7:1] = known_idx[$urandom_range(0, known_idx.size() - 1)];
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= r.action;
      req_palette_index <= r.pal_idx;
      req_palette_color <= r.pal_color;
      req_line_number   <= r.line;
      req_frame_count   <= r.frame;
      req_scroll_offset <= r.scroll;
      req_source_byte   <= r.src_byte;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      if (r.action == sps_pkg::ACT_PAL_WRITE || r.action == sps_pkg::ACT_LINE_START ||
          (r.action == sps_pkg::ACT_PIXEL && line_live &&
           (skip_left != 0 || src_taken < VIS_PIX)))
         useful_items++;
      if (r.action == sps_pkg::ACT_PAL_WRITE && !pal_known[r.pal_idx]) begin
         pal_known[r.pal_idx] = 1'b1;
         known_idx.push_back(r.pal_idx);
      end
      n = scale_request(r, px);
      if (typed) begin
         n     = n_typed;
         px[0] = typed_pix;
      end
      for (int k = 0; k < n; k++)
         pending_pixels.push_back(px[k]);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [5:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == sps_pkg::CSR_STRETCH_MODE)
         mode_now = value[1:0];
      else
         shift_now = value;
   endtask

   // drop valid, let every expected pixel drain, then allow for work still in flight
   task automatic settle();
      req_valid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // output side back-pressure
   initial begin : rsp_backpressure
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // sample between edges, where every signal is settled for the coming edge
   always @(negedge clock) begin : rsp_checker
      pixel_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               flag_mismatch($sformatf("unexpected pixel row %0d column %0d",
                                       rsp_out_row, rsp_out_column));
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_out_row !== want.row)
                  flag_mismatch($sformatf("row got %0d want %0d", rsp_out_row, want.row));
               if (rsp_out_column !== want.column)
                  flag_mismatch($sformatf("column got %0d want %0d",
                                          rsp_out_column, want.column));
               if (rsp_out_color !== want.color)
                  flag_mismatch($sformatf("colour got %h want %h", rsp_out_color, want.color));
               if (rsp_last_of_run !== want.last)
                  flag_mismatch($sformatf("last_of_run got %b want %b",
                                          rsp_last_of_run, want.last));
            end
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      step_type     dir_steps [$];
      line_req_type r;
      logic [1:0]   mode_plan [7];
      int           shift_plan [7];
      int           base_items;
      int           n_items;
      bit           want_long;
      bit           long_run;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = '0;
      req_palette_index = '0;
      req_palette_color = '0;
      req_line_number   = '0;
      req_frame_count   = '0;
      req_scroll_offset = '0;
      req_source_byte   = '0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      line_live         = 1'b0;
      row_now           = '0;
      src_taken         = '0;
      skip_left         = '0;
      col_next          = '0;
      dbl_phase         = '0;
      mode_now          = sps_pkg::MODE_ONE_TO_ONE;
      shift_now         = '0;
      errors            = 0;
      quiet_cycles      = 0;
      useful_items      = 0;
      idling_on         = 1'b1;
      for (int k = 0; k < PAL_DEPTH; k++) begin
         pal_shadow[k] = '0;
         pal_known[k]  = 1'b0;
      end

      // palette extremes and two mid entries
      dir_steps.push_back('{'{sps_pkg::ACT_PAL_WRITE, 7'd0, 16'h0000, 9'd0, 8'd0, 3'd0, 8'd0},
                            1'b1, 2'd0, '0});
      dir_steps.push_back('{'{sps_pkg::ACT_PAL_WRITE, 7'd127, 16'hFFFF, 9'd0, 8'd0, 3'd0, 8'd0},
                            1'b1, 2'd0, '0});
      dir_steps.push_back('{'{sps_pkg::ACT_PAL_WRITE, 7'd85, 16'hA5A5, 9'd0, 8'd0, 3'd0, 8'd0},
                            1'b1, 2'd0, '0});
      dir_steps.push_back('{'{sps_pkg::ACT_PAL_WRITE, 7'd42, 16'h5A5A, 9'd0, 8'd0, 3'd0, 8'd0},
                            1'b1, 2'd0, '0});
      // unused action with every field at its top, then a byte with no line open
      dir_steps.push_back('{'{ACT_IGNORED, 7'h7F, 16'hFFFF, 9'h1FF, 8'hFF, 3'h7, 8'hFF},
                            1'b1, 2'd0, '0});
      dir_steps.push_back('{'{sps_pkg::ACT_PIXEL, 7'd0, 16'h0, 9'd0, 8'd0, 3'd0, 8'hFF},
                            1'b1, 2'd0, '0});
      // lines outside the visible band
      dir_steps.push_back('{'{sps_pkg::ACT_LINE_START, 7'd0, 16'h0, 9'd0, 8'd0, 3'd0, 8'd0},
                            1'b1, 2'd0, '0});
      dir_steps.push_back('{'{sps_pkg::ACT_LINE_START, 7'd0, 16'h0, 9'd12, 8'd0, 3'd0, 8'd0},
                            1'b1, 2'd0, '0});
      dir_steps.push_back('{'{sps_pkg::ACT_LINE_START, 7'd0, 16'h0, 9'd261, 8'd255, 3'd7, 8'd0},
                            1'b1, 2'd0, '0});
      // first visible line: eight bytes skipped, then pixels from column 72
      dir_steps.push_back('{'{sps_pkg::ACT_LINE_START, 7'd0, 16'h0, 9'd13, 8'd0, 3'd0, 8'd0},
                            1'b1, 2'd0, '0});
      for (int k = 0; k < 8; k++)
         dir_steps.push_back('{'{sps_pkg::ACT_PIXEL, 7'd0, 16'h0, 9'd0, 8'd0, 3'd0,
                                 8'(8'h11 * k)}, 1'b1, 2'd0, '0});
      dir_steps.push_back('{'{sps_pkg::ACT_PIXEL, 7'd0, 16'h0, 9'd0, 8'd0, 3'd0, 8'hFF},
                            1'b1, 2'd1, '{8'd0, 9'd72, 16'hFFFF, 1'b1}});
      dir_steps.push_back('{'{sps_pkg::ACT_PIXEL, 7'd0, 16'h0, 9'd0, 8'd0, 3'd0, 8'h00},
                            1'b1, 2'd1, '{8'd0, 9'd73, 16'h0000, 1'b1}});
      dir_steps.push_back('{'{sps_pkg::ACT_PIXEL, 7'd0, 16'h0, 9'd0, 8'd0, 3'd0, 8'hAB},
                            1'b0, 2'd0, '0});
      // last visible line with the largest skip
      dir_steps.push_back('{'{sps_pkg::ACT_LINE_START, 7'd0, 16'h0, 9'd228, 8'd255, 3'd7, 8'd0},
                            1'b1, 2'd0, '0});
      dir_steps.push_back('{'{sps_pkg::ACT_PIXEL, 7'd0, 16'h0, 9'd0, 8'd0, 3'd0, 8'h54},
                            1'b0, 2'd0, '0});

      mode_plan  = '{sps_pkg::MODE_FOUR_FIVE, sps_pkg::MODE_TWO_THREE, MODE_SPARE,
                     sps_pkg::MODE_ONE_TO_ONE, sps_pkg::MODE_FOUR_FIVE,
                     sps_pkg::MODE_TWO_THREE, sps_pkg::MODE_ONE_TO_ONE};
      shift_plan = '{0, 63, -1, 63, -1, -1, 0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_steps[k])
         issue_request(dir_steps[k].req, dir_steps[k].typed, dir_steps[k].n_pix,
                       dir_steps[k].first_pix);

      for (int ph = 0; ph < 7; ph++) begin
         settle();
         write_csr(sps_pkg::CSR_STRETCH_MODE, {4'd0, mode_plan[ph]});
         write_csr(sps_pkg::CSR_COLUMN_SHIFT, shift_plan[ph] < 0 ? 6'($urandom_range(0, 63))
                                                                 : 6'(shift_plan[ph]));
         idling_on  = (ph != 6);
         want_long  = (ph == 5);
         base_items = useful_items;
         // carry on whatever line is open, now under the new mode
         repeat ($urandom_range(1, 3)) begin
            r        = line_req_type'(REQ_BITS'({$urandom, $urandom}));
            r.action = sps_pkg::ACT_PIXEL;
            issue_request(r, 1'b0, 2'd0, '0);
         end
         while (useful_items - base_items < PHASE_ITEMS) begin
            idling_on = (ph != 6) && ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 4) == 0) begin
               // stray requests with any action and any field value
               repeat ($urandom_range(1, 4))
                  issue_request(line_req_type'(REQ_BITS'({$urandom, $urandom})),
                                1'b0, 2'd0, '0);
            end else begin
               r        = line_req_type'(REQ_BITS'({$urandom, $urandom}));
               r.action = sps_pkg::ACT_LINE_START;
               case ($urandom_range(0, 7))
                  0:       r.line = 9'(TOP_LINE);
                  1:       r.line = 9'(TOP_LINE + sps_pkg::ACTIVE_ROWS - 1);
                  default: r.line = 9'($urandom_range(TOP_LINE,
                                                      TOP_LINE + sps_pkg::ACTIVE_ROWS - 1));
               endcase
               issue_request(r, 1'b0, 2'd0, '0);
               long_run  = want_long;
               want_long = 1'b0;
               // a long run passes the visible width so trailing bytes are dropped
               n_items = sps_pkg::BASE_SKIP + r.scroll +
                         (long_run ? VIS_PIX + $urandom_range(1, 6) : $urandom_range(0, 20));
               repeat (n_items) begin
                  r = line_req_type'(REQ_BITS'({$urandom, $urandom}));
                  if (!long_run && $urandom_range(0, 9) == 0)
                     r.action = sps_pkg::ACT_PAL_WRITE;
                  else
                     r.action = sps_pkg::ACT_PIXEL;
                  issue_request(r, 1'b0, 2'd0, '0);
               end
            end
         end
      end

      idling_on = 1'b0;
      settle();
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/sps_pkg.sv
hdl/scanline_palette_stretch.sv
tb/tb_scanline_palette_stretch.sv
